// File: rtl/gait_phase_scheduler_assert.svh
// Assertion macros for the gait phase scheduler.
// Expects clk and rst_n in the scope of use.
`ifndef GAIT_PHASE_SCHEDULER_ASSERT_SVH
`define GAIT_PHASE_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define GPS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gait_phase_scheduler: assertion failed");

// next-cycle implication
`define GPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gait_phase_scheduler: assertion failed");

`endif

// File: rtl/gps_pkg.sv
// Package for the gait phase scheduler: widths, register indexes and types.
// No dependencies.
`timescale 1ns / 1ps
package gps_pkg;

    localparam int ITER_W          = 32;
    localparam int REM_W           = 16;
    localparam int TICK_W          = 15;
    localparam int SEG_W           = 5;
    localparam int IPS_W           = 11;
    localparam int PHASE_W         = 4;
    localparam int OFF_W           = 4;
    localparam int DUR_W           = 5;
    localparam int OFFSETS_W       = 16;
    localparam int DURATIONS_W     = 20;
    localparam int CFG_DATA_W      = 20;
    localparam int LEG_SLOTS       = 4;
    localparam int LANES           = 2 * LEG_SLOTS;
    localparam int SEG_SLOTS       = 16;
    localparam int HORIZON_W       = LEG_SLOTS * SEG_SLOTS;
    localparam int STEPS_PER_STAGE = 4;
    localparam int MAX_IPS         = 1024;

    localparam logic [SEG_W-1:0]       SEG_COUNT_RST = 5'd10;
    localparam logic [IPS_W-1:0]       IPS_RST       = 11'd1;
    localparam logic [OFFSETS_W-1:0]   OFFSETS_RST   = 16'd1360;
    localparam logic [DURATIONS_W-1:0] DURATIONS_RST = 20'd169125;

    typedef enum logic [1:0] {
        CFG_SEG_COUNT = 2'd0,
        CFG_IPS       = 2'd1,
        CFG_OFFSETS   = 2'd2,
        CFG_DURATIONS = 2'd3
    } gps_cfg_idx_t;

    typedef struct packed {
        logic [SEG_W-1:0]                  n;
        logic [IPS_W-1:0]                  ips;
        logic [TICK_W-1:0]                 period;
        logic [LEG_SLOTS-1:0][OFF_W-1:0]   off;
        logic [LEG_SLOTS-1:0][DUR_W-1:0]   dur;
        logic [LANES-1:0][TICK_W-1:0]      start;
        logic [LANES-1:0][TICK_W-1:0]      len;
        logic [LANES-1:0]                  lane_on;
    } gps_cfg_t;

endpackage

// File: rtl/gait_phase_scheduler.sv
// Top level of the gait phase scheduler: config registers, tick pipeline, outputs.
// Depends on gps_pkg, gps_div_stage and gait_phase_scheduler_assert.svh.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------------
//   cfg       | cfg_we               | cfg_index, cfg_data
//   in        | in_valid / in_stall  | current_iteration
//   out       | out_valid / out_stall| gait_phase, contact/swing progress, horizon
//
// One item per cycle sustained while out_stall is low. Stages: input register,
// tick-modulo divider (4 bits a stage), phase stage, progress dividers (4 bits
// a stage), output register. Reset empties the pipeline and loads the default
// config. A stalled stage holds; upstream stages fill empty slots behind it.
`timescale 1ns / 1ps
module gait_phase_scheduler
    import gps_pkg::*;
#(
    parameter int MAX_SEGMENTS  = 16,
    parameter int LEG_COUNT     = 4,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ITER_W-1:0]         current_iteration,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [PHASE_W-1:0]        gait_phase,
    output logic [FRACTION_BITS:0]    contact_progress_0,
    output logic [FRACTION_BITS:0]    contact_progress_1,
    output logic [FRACTION_BITS:0]    contact_progress_2,
    output logic [FRACTION_BITS:0]    contact_progress_3,
    output logic [FRACTION_BITS:0]    swing_progress_0,
    output logic [FRACTION_BITS:0]    swing_progress_1,
    output logic [FRACTION_BITS:0]    swing_progress_2,
    output logic [FRACTION_BITS:0]    swing_progress_3,
    output logic [HORIZON_W-1:0]      horizon_table
);

    localparam int SPS    = STEPS_PER_STAGE;
    localparam int MOD_ST = (ITER_W + SPS - 1) / SPS;
    localparam int DIV_ST = (FRACTION_BITS + SPS - 1) / SPS;
    localparam int ST_A   = MOD_ST + 1;
    localparam int ST_D0  = ST_A + 1;
    localparam int ST_O   = ST_A + DIV_ST + 1;
    localparam int NST    = ST_O + 1;
    localparam int PW     = FRACTION_BITS + 1;

    // config registers
    logic [SEG_W-1:0]       seg_count_reg;
    logic [IPS_W-1:0]       ips_reg;
    logic [OFFSETS_W-1:0]   offsets_reg;
    logic [DURATIONS_W-1:0] durations_reg;
    gps_cfg_t               cfgd_reg, cfgd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= SEG_COUNT_RST;
            ips_reg       <= IPS_RST;
            offsets_reg   <= OFFSETS_RST;
            durations_reg <= DURATIONS_RST;
        end
        else if (cfg_we)
        begin
            case (gps_cfg_idx_t'(cfg_index))
                CFG_SEG_COUNT: seg_count_reg <= cfg_data[SEG_W-1:0];
                CFG_IPS:       ips_reg       <= cfg_data[IPS_W-1:0];
                CFG_OFFSETS:   offsets_reg   <= cfg_data[OFFSETS_W-1:0];
                CFG_DURATIONS: durations_reg <= cfg_data[DURATIONS_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin : cfg_derive
        logic [SEG_W-1:0]  n;
        logic [IPS_W-1:0]  ips;
        logic [8:0]        r;
        logic [8:0]        d;
        logic [DUR_W-1:0]  dur;
        logic [5:0]        ss;
        cfgd_next = '0;
        if (seg_count_reg == '0)
            n = SEG_W'(1);
        else if (seg_count_reg > SEG_W'(MAX_SEGMENTS))
            n = SEG_W'(MAX_SEGMENTS);
        else
            n = seg_count_reg;
        if (ips_reg == '0)
            ips = IPS_W'(1);
        else if (ips_reg > IPS_W'(MAX_IPS))
            ips = IPS_W'(MAX_IPS);
        else
            ips = ips_reg;
        cfgd_next.n      = n;
        cfgd_next.ips    = ips;
        cfgd_next.period = TICK_W'(TICK_W'(n) * TICK_W'(ips));
        for (int l = 0; l < LEG_SLOTS; l++)
        begin
            r = 9'(offsets_reg[OFF_W*l +: OFF_W]);
            for (int k = 3; k >= 0; k--)
            begin
                d = 9'(n) << k;
                if (r >= d)
                    r = r - d;
            end
            dur = durations_reg[DUR_W*l +: DUR_W];
            if (dur > n)
                dur = n;
            ss = 6'(r[OFF_W-1:0]) + 6'(dur);
            if (ss >= 6'(n))
                ss = ss - 6'(n);
            cfgd_next.off[l]          = r[OFF_W-1:0];
            cfgd_next.dur[l]          = dur;
            cfgd_next.start[l]        = TICK_W'(TICK_W'(r[OFF_W-1:0]) * TICK_W'(ips));
            cfgd_next.len[l]          = TICK_W'(TICK_W'(dur) * TICK_W'(ips));
            cfgd_next.start[l+LEG_SLOTS] = TICK_W'(TICK_W'(ss) * TICK_W'(ips));
            cfgd_next.len[l+LEG_SLOTS]   = TICK_W'(TICK_W'(n - dur) * TICK_W'(ips));
            cfgd_next.lane_on[l]           = (l < LEG_COUNT);
            cfgd_next.lane_on[l+LEG_SLOTS] = (l < LEG_COUNT);
        end
    end

    always_ff @(posedge clk)
    begin
        cfgd_reg <= cfgd_next;
    end

    // pipeline control
    logic [NST-1:0] v_reg;
    logic [NST:0]   ready;

    always_comb
    begin
        ready[NST] = !out_stall;
        for (int k = NST - 1; k >= 0; k--)
            ready[k] = !v_reg[k] || ready[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ready[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (ready[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = v_reg[ST_O];

    // input stage
    logic [ITER_W-1:0] x_reg;

    always_ff @(posedge clk)
    begin
        if (ready[0])
            x_reg <= current_iteration;
    end

    // tick modulo period
    logic [REM_W-1:0]  mrem [MOD_ST+1];
    logic [ITER_W-1:0] mq   [MOD_ST+1];
    logic [REM_W-1:0]  mod_den;

    assign mrem[0] = '0;
    assign mq[0]   = x_reg;
    assign mod_den = REM_W'(cfgd_reg.period);

    genvar j;
    for (j = 0; j < MOD_ST; j++)
    begin : g_mod
        localparam int STEPS_J = (ITER_W - j * SPS < SPS) ? (ITER_W - j * SPS) : SPS;
        gps_div_stage #(
            .LANES_N (1),
            .QW      (ITER_W),
            .STEPS   (STEPS_J)
        ) u_mod (
            .clk     (clk),
            .en      (ready[1+j]),
            .rem_in  (mrem[j]),
            .den     (mod_den),
            .q_in    (mq[j]),
            .rem_out (mrem[j+1]),
            .q_out   (mq[j+1])
        );
    end

    // phase and window offsets
    logic [PHASE_W-1:0]          a_phase_reg, a_phase_next;
    logic [LANES-1:0][REM_W-1:0] a_e_reg, a_e_next;
    logic [LANES-1:0]            a_zero_reg, a_zero_next, a_full_reg, a_full_next;

    always_comb
    begin : phase_logic
        logic [TICK_W-1:0] t;
        logic [REM_W-1:0]  pr;
        logic [REM_W-1:0]  pd;
        logic [REM_W-1:0]  e;
        t  = mrem[MOD_ST][TICK_W-1:0];
        pr = REM_W'(t);
        a_phase_next = '0;
        for (int k = PHASE_W - 1; k >= 0; k--)
        begin
            pd = REM_W'(cfgd_reg.ips) << k;
            if (pr >= pd)
            begin
                pr = pr - pd;
                a_phase_next[k] = 1'b1;
            end
        end
        for (int ln = 0; ln < LANES; ln++)
        begin
            e = REM_W'(t) - REM_W'(cfgd_reg.start[ln]);
            if (t < cfgd_reg.start[ln])
                e = e + REM_W'(cfgd_reg.period);
            a_e_next[ln]    = e;
            a_zero_next[ln] = !cfgd_reg.lane_on[ln] || (cfgd_reg.len[ln] == '0)
                              || (e > REM_W'(cfgd_reg.len[ln]));
            a_full_next[ln] = (e == REM_W'(cfgd_reg.len[ln]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_A])
        begin
            a_phase_reg <= a_phase_next;
            a_e_reg     <= a_e_next;
            a_zero_reg  <= a_zero_next;
            a_full_reg  <= a_full_next;
        end
    end

    // progress dividers
    logic [LANES-1:0][REM_W-1:0]         drem [DIV_ST+1];
    logic [LANES-1:0][FRACTION_BITS-1:0] dq   [DIV_ST+1];
    logic [LANES-1:0][REM_W-1:0]         dden;
    logic [PHASE_W-1:0]                  d_phase_reg [DIV_ST];
    logic [LANES-1:0]                    d_zero_reg  [DIV_ST];
    logic [LANES-1:0]                    d_full_reg  [DIV_ST];

    assign drem[0] = a_e_reg;
    assign dq[0]   = '0;

    always_comb
    begin
        for (int ln = 0; ln < LANES; ln++)
            dden[ln] = REM_W'(cfgd_reg.len[ln]);
    end

    genvar g;
    for (g = 0; g < DIV_ST; g++)
    begin : g_div
        localparam int STEPS_G =
            (FRACTION_BITS - g * SPS < SPS) ? (FRACTION_BITS - g * SPS) : SPS;
        gps_div_stage #(
            .LANES_N (LANES),
            .QW      (FRACTION_BITS),
            .STEPS   (STEPS_G)
        ) u_div (
            .clk     (clk),
            .en      (ready[ST_D0+g]),
            .rem_in  (drem[g]),
            .den     (dden),
            .q_in    (dq[g]),
            .rem_out (drem[g+1]),
            .q_out   (dq[g+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_D0])
        begin
            d_phase_reg[0] <= a_phase_reg;
            d_zero_reg[0]  <= a_zero_reg;
            d_full_reg[0]  <= a_full_reg;
        end
        for (int k = 1; k < DIV_ST; k++)
        begin
            if (ready[ST_D0+k])
            begin
                d_phase_reg[k] <= d_phase_reg[k-1];
                d_zero_reg[k]  <= d_zero_reg[k-1];
                d_full_reg[k]  <= d_full_reg[k-1];
            end
        end
    end

    // output stage
    logic [PHASE_W-1:0]          phase_out_reg;
    logic [LANES-1:0][PW-1:0]    prog_reg, prog_next;
    logic [HORIZON_W-1:0]        horizon_reg, horizon_next;

    always_comb
    begin : out_logic
        logic [PHASE_W-1:0] ph;
        logic [5:0]         seg;
        logic [5:0]         rel;
        logic [5:0]         n6;
        logic [5:0]         off6;
        ph   = d_phase_reg[DIV_ST-1];
        n6   = 6'(cfgd_reg.n);
        for (int ln = 0; ln < LANES; ln++)
        begin
            if (d_zero_reg[DIV_ST-1][ln])
                prog_next[ln] = '0;
            else if (d_full_reg[DIV_ST-1][ln])
                prog_next[ln] = PW'(1) << FRACTION_BITS;
            else
                prog_next[ln] = {1'b0, dq[DIV_ST][ln]};
        end
        horizon_next = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            for (int lg = 0; lg < LEG_COUNT; lg++)
            begin
                off6 = 6'(cfgd_reg.off[lg]);
                seg  = 6'(i) + 6'(ph) + 6'd1;
                if (seg >= n6)
                    seg = seg - n6;
                if (seg >= off6)
                    rel = seg - off6;
                else
                    rel = seg + n6 - off6;
                if ((6'(i) < n6) && (rel < 6'(cfgd_reg.dur[lg])))
                    horizon_next[LEG_SLOTS*i + lg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_O])
        begin
            phase_out_reg <= d_phase_reg[DIV_ST-1];
            prog_reg      <= prog_next;
            horizon_reg   <= horizon_next;
        end
    end

    assign gait_phase         = phase_out_reg;
    assign contact_progress_0 = prog_reg[0];
    assign contact_progress_1 = prog_reg[1];
    assign contact_progress_2 = prog_reg[2];
    assign contact_progress_3 = prog_reg[3];
    assign swing_progress_0   = prog_reg[LEG_SLOTS];
    assign swing_progress_1   = prog_reg[LEG_SLOTS+1];
    assign swing_progress_2   = prog_reg[LEG_SLOTS+2];
    assign swing_progress_3   = prog_reg[LEG_SLOTS+3];
    assign horizon_table      = horizon_reg;

`include "gait_phase_scheduler_assert.svh"

    `GPS_ASSERT_IMPL(a_leg0_excl, out_valid, (contact_progress_0 == '0) || (swing_progress_0 == '0))
    `GPS_ASSERT_IMPL(a_phase_range, out_valid, SEG_W'(gait_phase) < cfgd_reg.n)
    `GPS_ASSERT_IMPL(a_drain, !v_reg[ST_O], !in_stall)
    `GPS_ASSERT_NEXT(a_take, in_valid && !in_stall, v_reg[0])

endmodule

// File: rtl/gps_div_stage.sv
// One pipeline stage of restoring division: STEPS quotient bits per lane.
// Depends on gps_pkg.
`timescale 1ns / 1ps
module gps_div_stage
    import gps_pkg::*;
#(
    parameter int LANES_N = 1,
    parameter int QW      = 32,
    parameter int STEPS   = 4
)
(
    input  logic                             clk,
    input  logic                             en,
    input  logic [LANES_N-1:0][REM_W-1:0]    rem_in,
    input  logic [LANES_N-1:0][REM_W-1:0]    den,
    input  logic [LANES_N-1:0][QW-1:0]       q_in,
    output logic [LANES_N-1:0][REM_W-1:0]    rem_out,
    output logic [LANES_N-1:0][QW-1:0]       q_out
);

    logic [LANES_N-1:0][REM_W-1:0] rem_reg, rem_next;
    logic [LANES_N-1:0][QW-1:0]    q_reg, q_next;

    always_comb
    begin : step_logic
        logic [REM_W-1:0] r;
        logic [QW-1:0]    q;
        for (int ln = 0; ln < LANES_N; ln++)
        begin
            r = rem_in[ln];
            q = q_in[ln];
            for (int s = 0; s < STEPS; s++)
            begin
                r = {r[REM_W-2:0], q[QW-1]};
                q = {q[QW-2:0], 1'b0};
                if (r >= den[ln])
                begin
                    r    = r - den[ln];
                    q[0] = 1'b1;
                end
            end
            rem_next[ln] = r;
            q_next[ln]   = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

// File: tb/gait_phase_scheduler_tb.sv
// Testbench for gait_phase_scheduler: random and directed ticks over several schedules,
// each result checked against an in-bench schedule predictor.
// Depends on gps_pkg and the gait_phase_scheduler RTL.
`timescale 1ns / 1ps
module gait_phase_scheduler_tb;
    import gps_pkg::*;

    localparam int FRAC       = 16;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [PHASE_W-1:0]            phase;
        logic [LEG_SLOTS-1:0][FRAC:0]  contact;
        logic [LEG_SLOTS-1:0][FRAC:0]  swing;
        logic [HORIZON_W-1:0]          horizon;
    } tick_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = CFG_SEG_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [ITER_W-1:0]     current_iteration = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PHASE_W-1:0]    gait_phase;
    logic [FRAC:0]         contact_progress_0, contact_progress_1;
    logic [FRAC:0]         contact_progress_2, contact_progress_3;
    logic [FRAC:0]         swing_progress_0, swing_progress_1;
    logic [FRAC:0]         swing_progress_2, swing_progress_3;
    logic [HORIZON_W-1:0]  horizon_table;

    gait_phase_scheduler dut (.*);

    // schedule registers as last written
    logic [SEG_W-1:0]       sched_segs = SEG_COUNT_RST;
    logic [IPS_W-1:0]       sched_ips  = IPS_RST;
    logic [OFFSETS_W-1:0]   sched_offs = OFFSETS_RST;
    logic [DURATIONS_W-1:0] sched_durs = DURATIONS_RST;

    logic [ITER_W-1:0] pending_ticks[$];
    tick_result_t      expected_ticks[$];
    int                errors = 0;
    int                cycles = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic              hold_go = 1'b0;
    int                hold_left = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int eff_segs();
        int n;
        n = sched_segs;
        if (n == 0) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    function automatic int eff_ips();
        int v;
        v = sched_ips;
        if (v == 0) v = 1;
        if (v > MAX_IPS) v = MAX_IPS;
        return v;
    endfunction

    function automatic logic [FRAC:0] window_frac(int t, int start, int len, int period);
        longint e;
        if (len == 0) return '0;
        e = (t + period - start) % period;
        if (e > len) return '0;
        return (FRAC+1)'((e << FRAC) / len);
    endfunction

    function automatic tick_result_t schedule_tick(logic [ITER_W-1:0] iter);
        tick_result_t r;
        int n, ips, period, t, ph, off, dur, sw, seg;
        n = eff_segs();
        ips = eff_ips();
        period = n * ips;
        t = int'({32'd0, iter} % period);
        ph = t / ips;
        r = '0;
        r.phase = ph[PHASE_W-1:0];
        for (int leg = 0; leg < LEG_SLOTS; leg++) begin
            off = sched_offs[4*leg +: 4] % n;
            dur = sched_durs[5*leg +: 5];
            if (dur > n) dur = n;
            sw = (off + dur) % n;
            r.contact[leg] = window_frac(t, off * ips, dur * ips, period);
            r.swing[leg] = window_frac(t, sw * ips, (n - dur) * ips, period);
            for (int i = 0; i < n; i++) begin
                seg = (i + ph + 1) % n;
                if ((seg + n - off) % n < dur) r.horizon[4*i + leg] = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && in_stall)) begin
            if (in_valid) expected_ticks.push_back(schedule_tick(current_iteration));
            if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                current_iteration <= pending_ticks.pop_front();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (hold_go) hold_left <= 80;
        else if (hold_left != 0) hold_left <= hold_left - 1;
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end

    // monitor
    always @(posedge clk) begin
        tick_result_t got, want;
        if (rst_n && out_valid && !out_stall) begin
            got.phase = gait_phase;
            got.contact = {contact_progress_3, contact_progress_2,
                           contact_progress_1, contact_progress_0};
            got.swing = {swing_progress_3, swing_progress_2,
                         swing_progress_1, swing_progress_0};
            got.horizon = horizon_table;
            if (expected_ticks.size() == 0) begin
                report_mismatch("unexpected item", 64'd0, 64'd0);
            end
            else begin
                want = expected_ticks.pop_front();
                if (got.phase != want.phase)
                    report_mismatch("gait_phase", 64'(got.phase), 64'(want.phase));
                for (int leg = 0; leg < LEG_SLOTS; leg++) begin
                    if (got.contact[leg] != want.contact[leg])
                        report_mismatch($sformatf("contact_progress_%0d", leg),
                                        64'(got.contact[leg]), 64'(want.contact[leg]));
                    if (got.swing[leg] != want.swing[leg])
                        report_mismatch($sformatf("swing_progress_%0d", leg),
                                        64'(got.swing[leg]), 64'(want.swing[leg]));
                end
                if (got.horizon != want.horizon)
                    report_mismatch("horizon_table", got.horizon, want.horizon);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(gps_cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_SEG_COUNT: sched_segs = v[SEG_W-1:0];
            CFG_IPS:       sched_ips = v[IPS_W-1:0];
            CFG_OFFSETS:   sched_offs = v[OFFSETS_W-1:0];
            CFG_DURATIONS: sched_durs = v[DURATIONS_W-1:0];
            default:       ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || expected_ticks.size() != 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        int period;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: window edges at reset schedule, extremes of the tick count
        for (int i = 0; i < 12; i++) pending_ticks.push_back(ITER_W'(i));
        pending_ticks.push_back(32'hFFFF_FFFF);
        pending_ticks.push_back(32'h8000_0000);
        pending_ticks.push_back(32'h7FFF_FFFF);
        pending_ticks.push_back(32'h5555_5555);
        pending_ticks.push_back(32'hAAAA_AAAA);
        drain();

        // zero-length windows: durations zero and full
        write_reg(CFG_DURATIONS, {5'd31, 5'd10, 5'd0, 5'd5});
        write_reg(CFG_OFFSETS, 20'h0FF90);
        for (int i = 0; i < 6; i++) pending_ticks.push_back(ITER_W'(i * 3));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_SEG_COUNT, 20'd16);
                    write_reg(CFG_IPS, 20'd1024);
                end
                1: begin
                    write_reg(CFG_SEG_COUNT, 20'd1);
                    write_reg(CFG_IPS, 20'd1);
                end
                2: begin
                    write_reg(CFG_SEG_COUNT, 20'd0);
                    write_reg(CFG_IPS, 20'd0);
                end
                3: begin
                    write_reg(CFG_SEG_COUNT, 20'hFFFFF);
                    write_reg(CFG_IPS, 20'hFFFFF);
                end
                default: begin
                    write_reg(CFG_SEG_COUNT, 20'($urandom_range(16, 1)));
                    write_reg(CFG_IPS, 20'($urandom_range(8, 1)));
                end
            endcase
            write_reg(CFG_OFFSETS,
                      ph == 0 ? 20'hFFFF : 20'($urandom_range(20'hFFFF, 0)));
            write_reg(CFG_DURATIONS,
                      ph == 1 ? 20'hFFFFF : 20'($urandom_range(20'hFFFFF, 0)));
            send_idle_pct = (ph % 3 == 0) ? 11 : (ph % 3 == 1) ? 75 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 75 : (ph % 3 == 1) ? 11 : 0;
            period = eff_segs() * eff_ips();
            for (int i = 0; i < 210; i++) begin
                if ($urandom_range(2) == 0) pending_ticks.push_back($urandom());
                else pending_ticks.push_back($urandom_range(3 * period, 0));
            end
            if (ph == 5) begin
                @(posedge clk);
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            drain();
        end

        if (errors == 0 && expected_ticks.size() == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
